// ----- hdl/ccg_pkg.sv -----
package ccg_pkg;

	localparam int COLOR_W = 8;
	localparam int STEP_W  = 16;
	localparam int COUNT_W = 4;
	localparam int INDEX_W = 3;
	localparam int NUM_W   = STEP_W + COLOR_W;

	localparam int DEFAULT_PALETTE_DEPTH = 8;

	localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd60;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic REG_STEP_TICKS  = 1'b0;
	localparam logic REG_COLOR_COUNT = 1'b1;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_START,
		ST_DIV
	} state_t;

endpackage

// ----- hdl/ccg_palette.sv -----
module ccg_palette
	import ccg_pkg::*;
#(
	parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH,
	parameter int AW = $clog2(PALETTE_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  rgb_t          wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_cur,
	input  logic [AW-1:0] rd_addr_nxt,
	output rgb_t          rd_cur,
	output rgb_t          rd_nxt
);

	rgb_t mem [PALETTE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_cur <= mem[rd_addr_cur];
			rd_nxt <= mem[rd_addr_nxt];
		end
	end

endmodule

// ----- hdl/ccg_div.sv -----
module ccg_div
	import ccg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [STEP_W-1:0]  den,
	output logic [COLOR_W-1:0] quo,
	output logic               done
);

	localparam int CNT_W = $clog2(COLOR_W + 1);

	logic [STEP_W-1:0]  rem_q;
	logic [COLOR_W-1:0] sh_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STEP_W:0]    trial;
	logic [STEP_W:0]    diff;
	logic               fits;

	// quotient is known to fit in COLOR_W bits, so the top of num starts below den
	assign trial = {rem_q, sh_q[COLOR_W-1]};
	assign diff  = trial - {1'b0, den};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(COLOR_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:COLOR_W];
			sh_q  <= num[COLOR_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
			sh_q  <= {sh_q[COLOR_W-2:0], fits};
		end
	end

	assign quo  = sh_q;
	assign done = cnt_q == '0;

endmodule

// ----- hdl/cyclic_color_gradient.sv -----
// tick item: palette read, blend multiply and the 8-step serial divider per channel give
// a registered result; a load item gives no result. One item in flight at a time: a tick
// item holds the input until its result enters the output register, a load item does not.
// reset clears tick counter and segment, step_ticks to 60, color_count to 1
// palette entries are not cleared and hold nothing until loaded
module cyclic_color_gradient
	import ccg_pkg::*;
#(
	parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic [COLOR_W-1:0] entry_red,
	input  logic [COLOR_W-1:0] entry_green,
	input  logic [COLOR_W-1:0] entry_blue,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] out_red,
	output logic [COLOR_W-1:0] out_green,
	output logic [COLOR_W-1:0] out_blue,
	output logic [INDEX_W-1:0] segment_now,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW    = $clog2(PALETTE_DEPTH);
	localparam int CMP_W = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

	state_t state_q, state_d;

	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] count_q;
	logic [STEP_W-1:0]  tick_q;
	logic [AW-1:0]      seg_q;

	logic in_accept, tick_accept, rd_en, mul_en, div_start, out_load;
	logic [STEP_W-1:0] step_eff, tick_inc, tick_nxt;
	logic [CMP_W-1:0]  count_eff, ld_ext, seg_ext;
	logic [AW-1:0]     seg_succ, seg_nxt, seg_after;
	logic              ld_in_range;

	rgb_t rd_cur, rd_nxt, wr_data;
	logic [NUM_W-1:0] num_r_q, num_g_q, num_b_q;
	logic [COLOR_W-1:0] quo_r, quo_g, quo_b;
	logic done_r, done_g, done_b;

	logic               out_valid_q;
	rgb_t               out_q;
	logic [INDEX_W-1:0] out_seg_q;

	function automatic logic [AW-1:0] succ(input logic [AW-1:0] s, input logic [CMP_W-1:0] c);
		logic [CMP_W-1:0] n;
		n = CMP_W'(s) + 1'b1;
		return (n >= c) ? '0 : n[AW-1:0];
	endfunction

	function automatic logic [NUM_W-1:0] blend_num(input logic [COLOR_W-1:0] c,
			input logic [COLOR_W-1:0] n, input logic [STEP_W-1:0] wc,
			input logic [STEP_W-1:0] wn);
		return NUM_W'(c) * NUM_W'(wc) + NUM_W'(n) * NUM_W'(wn);
	endfunction

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RESET;
			count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_STEP_TICKS:  step_q  <= pwdata[STEP_W-1:0];
				REG_COLOR_COUNT: count_q <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_STEP_TICKS:  prdata = {16'b0, step_q};
			REG_COLOR_COUNT: prdata = {28'b0, count_q};
			default:         prdata = '0;
		endcase
	end

	// effective settings
	always_comb begin
		step_eff  = (step_q == '0) ? STEP_W'(1) : step_q;
		count_eff = CMP_W'(count_q);
		if (count_eff == '0) begin
			count_eff = CMP_W'(1);
		end
		if (count_eff > CMP_W'(PALETTE_DEPTH)) begin
			count_eff = CMP_W'(PALETTE_DEPTH);
		end
	end

	assign in_accept   = in_valid && in_ready;
	assign tick_accept = in_accept && (cmd == CMD_TICK);

	assign tick_inc  = tick_q + 1'b1;
	assign seg_succ  = succ(seg_q, count_eff);
	assign tick_nxt  = (tick_inc >= step_eff) ? '0 : tick_inc;
	assign seg_nxt   = (tick_inc >= step_eff) ? seg_succ : seg_q;
	assign seg_after = seg_succ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			seg_q  <= '0;
		end else if (tick_accept) begin
			tick_q <= tick_nxt;
			seg_q  <= seg_nxt;
		end
	end

	// palette loads
	assign ld_ext      = CMP_W'(entry_index);
	assign ld_in_range = ld_ext < CMP_W'(PALETTE_DEPTH);
	assign wr_data     = '{red: entry_red, green: entry_green, blue: entry_blue};

	ccg_palette #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.AW(AW)
	) u_palette (
		.clk(clk),
		.wr_en(in_accept && (cmd == CMD_LOAD) && ld_in_range),
		.wr_addr(ld_ext[AW-1:0]),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr_cur(seg_q),
		.rd_addr_nxt(seg_after),
		.rd_cur(rd_cur),
		.rd_nxt(rd_nxt)
	);

	// blend numerators, one register ahead of the dividers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			num_r_q <= blend_num(rd_cur.red, rd_nxt.red, step_eff - tick_q, tick_q);
			num_g_q <= blend_num(rd_cur.green, rd_nxt.green, step_eff - tick_q, tick_q);
			num_b_q <= blend_num(rd_cur.blue, rd_nxt.blue, step_eff - tick_q, tick_q);
		end
	end

	ccg_div u_div_r (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_r_q), .den(step_eff), .quo(quo_r), .done(done_r)
	);

	ccg_div u_div_g (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_g_q), .den(step_eff), .quo(quo_g), .done(done_g)
	);

	ccg_div u_div_b (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_b_q), .den(step_eff), .quo(quo_b), .done(done_b)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (tick_accept) state_d = ST_READ;
			ST_READ:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (done_r && (!out_valid_q || out_ready)) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		mul_en    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready  = 1'b1;
			ST_READ:  rd_en     = 1'b1;
			ST_MUL:   mul_en    = 1'b1;
			ST_START: div_start = 1'b1;
			ST_DIV:   out_load  = done_r && (!out_valid_q || out_ready);
			default: ;
		endcase
	end

	// output register, a new item may enter while a result waits here
	assign seg_ext = CMP_W'(seg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q     <= '{red: quo_r, green: quo_g, blue: quo_b};
			out_seg_q <= seg_ext[INDEX_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign out_red     = out_q.red;
	assign out_green   = out_q.green;
	assign out_blue    = out_q.blue;
	assign segment_now = out_seg_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (done_r == done_g && done_g == done_b))
		else $error("divider lanes out of step");

	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DIV))
		else $error("result raised outside the divide phase");
`endif

endmodule

// ----- tb/sv/cyclic_color_gradient_tb.sv -----
module cyclic_color_gradient_tb;
	import ccg_pkg::*;

	localparam int DEPTH = DEFAULT_PALETTE_DEPTH;

	typedef struct packed {
		rgb_t               color;
		logic [INDEX_W-1:0] seg;
	} shade_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic               cmd;
		logic [INDEX_W-1:0] idx;
		rgb_t               color;
		logic               cfg_reg;
		logic [31:0]        cfg_data;
		logic               has_exp;
		shade_t             exp_shade;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               cmd = CMD_TICK;
	logic [INDEX_W-1:0] entry_index = '0;
	logic [COLOR_W-1:0] entry_red = '0;
	logic [COLOR_W-1:0] entry_green = '0;
	logic [COLOR_W-1:0] entry_blue = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COLOR_W-1:0] out_red;
	logic [COLOR_W-1:0] out_green;
	logic [COLOR_W-1:0] out_blue;
	logic [INDEX_W-1:0] segment_now;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// directed rows carry their own expectation alongside the payload
	logic   exp_given = 1'b0;
	shade_t exp_given_shade = '0;

	// gradient predictor state
	rgb_t               pal_m [DEPTH];
	logic [STEP_W-1:0]  tick_m = '0;
	logic [INDEX_W-1:0] seg_m = '0;
	logic [STEP_W-1:0]  cfg_step = STEP_RESET;
	logic [COUNT_W-1:0] cfg_count = COUNT_RESET;

	shade_t   shade_q [$];
	shade_t   pred_shade;
	shade_t   got_shade;
	dir_row_t dir_rows [];
	int       fail_count = 0;
	int       send_idle_pct = 0;
	int       stall_pct = 0;
	logic     pressure_on = 1'b0;
	logic     hold_off = 1'b0;

	cyclic_color_gradient i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.entry_index (entry_index),
		.entry_red   (entry_red),
		.entry_green (entry_green),
		.entry_blue  (entry_blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.segment_now (segment_now),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int live_count();
		int c;
		c = int'(cfg_count);
		if (c == 0) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	function automatic logic [INDEX_W-1:0] seg_after(logic [INDEX_W-1:0] s);
		int n;
		n = int'(s) + 1;
		return (n >= live_count()) ? '0 : INDEX_W'(n);
	endfunction

	function automatic logic [COLOR_W-1:0] mix(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b,
			logic [STEP_W-1:0] t, int step);
		int num;
		num = int'(a) * (step - int'(t)) + int'(b) * int'(t);
		return COLOR_W'(num / step);
	endfunction

	function automatic shade_t gradient_tick();
		int     step;
		rgb_t   c;
		rgb_t   n;
		shade_t s;
		step = (cfg_step == '0) ? 1 : int'(cfg_step);
		tick_m = tick_m + 1'b1;
		// a lowered step length clears a counter already past it
		if (int'(tick_m) >= step) begin
			tick_m = '0;
			seg_m = seg_after(seg_m);
		end
		c = pal_m[seg_m];
		n = pal_m[seg_after(seg_m)];
		s.color.red   = mix(c.red, n.red, tick_m, step);
		s.color.green = mix(c.green, n.green, tick_m, step);
		s.color.blue  = mix(c.blue, n.blue, tick_m, step);
		s.seg = seg_m;
		return s;
	endfunction

	function automatic dir_row_t row_load(logic [INDEX_W-1:0] idx, rgb_t c);
		return '{ROW_ITEM, CMD_LOAD, idx, c, REG_STEP_TICKS, 32'd0, 1'b0, '0};
	endfunction

	function automatic dir_row_t row_tick(logic has, rgb_t c, logic [INDEX_W-1:0] seg);
		return '{ROW_ITEM, CMD_TICK, '0, '0, REG_STEP_TICKS, 32'd0, has, '{c, seg}};
	endfunction

	function automatic dir_row_t row_cfg(logic sel, logic [31:0] data);
		return '{ROW_CFG, CMD_TICK, '0, '0, sel, data, 1'b0, '0};
	endfunction

	// predictor runs on every item the block takes
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (cmd == CMD_LOAD) begin
				pal_m[entry_index] = '{entry_red, entry_green, entry_blue};
			end else begin
				pred_shade = gradient_tick();
				if (exp_given) pred_shade = exp_given_shade;
				shade_q.push_back(pred_shade);
			end
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (shade_q.size() == 0) begin
				$error("result with no item waiting for it");
				fail_count++;
			end else begin
				got_shade = shade_q.pop_front();
				check_field("out_red", int'(got_shade.color.red), int'(out_red));
				check_field("out_green", int'(got_shade.color.green), int'(out_green));
				check_field("out_blue", int'(got_shade.color.blue), int'(out_blue));
				check_field("segment_now", int'(got_shade.seg), int'(segment_now));
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (pressure_on);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5000000;
		$display("** cyclic_color_gradient: FAILED **");
		$finish;
	end

	task automatic push_item(logic c, logic [INDEX_W-1:0] idx, rgb_t color, logic has,
			shade_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		cmd             <= c;
		entry_index     <= idx;
		entry_red       <= color.red;
		entry_green     <= color.green;
		entry_blue      <= color.blue;
		exp_given       <= has;
		exp_given_shade <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	// loads leave nothing to wait for, so wait on past the last result before moving on
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (shade_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic apb_write(logic sel, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_STEP_TICKS) cfg_step = data[STEP_W-1:0];
		else cfg_count = data[COUNT_W-1:0];
	endtask

	initial begin
		int          phase;
		int          chunk;
		int          k;
		int          pick;
		logic [31:0] step_pick;
		logic        c;

		dir_rows = '{
			row_load(3'd0, 24'hFF00FF),
			row_load(3'd1, 24'h00FF00),
			row_load(3'd2, 24'h804020),
			row_load(3'd3, 24'h0A141E),
			row_load(3'd4, 24'hC86432),
			row_load(3'd5, 24'h010203),
			row_load(3'd6, 24'hFFFFFF),
			row_load(3'd7, 24'h000000),
			// one palette colour: blends with itself
			row_tick(1'b1, 24'hFF00FF, 3'd0),
			// zero step and zero count both act as one, counter already past the step
			row_cfg(REG_STEP_TICKS, 32'd0),
			row_cfg(REG_COLOR_COUNT, 32'd0),
			row_tick(1'b1, 24'hFF00FF, 3'd0),
			// count above the palette depth saturates
			row_cfg(REG_COLOR_COUNT, 32'd15),
			row_tick(1'b1, 24'h00FF00, 3'd1),
			row_tick(1'b1, 24'h804020, 3'd2),
			row_tick(1'b1, 24'h0A141E, 3'd3),
			row_tick(1'b1, 24'hC86432, 3'd4),
			row_tick(1'b1, 24'h010203, 3'd5),
			row_tick(1'b1, 24'hFFFFFF, 3'd6),
			row_tick(1'b1, 24'h000000, 3'd7),
			// segment beyond the count blends toward entry 0, then wraps there
			row_cfg(REG_STEP_TICKS, 32'd2),
			row_cfg(REG_COLOR_COUNT, 32'd3),
			row_tick(1'b1, 24'h7F007F, 3'd7),
			row_tick(1'b1, 24'hFF00FF, 3'd0),
			row_cfg(REG_STEP_TICKS, 32'd65535),
			row_tick(1'b0, 24'h000000, 3'd0)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				drain();
				apb_write(dir_rows[k].cfg_reg, dir_rows[k].cfg_data);
			end else begin
				push_item(dir_rows[k].cmd, dir_rows[k].idx, dir_rows[k].color,
					dir_rows[k].has_exp, dir_rows[k].exp_shade);
			end
		end

		for (phase = 0; phase < 4; phase++) begin
			drain();
			send_idle_pct = (phase == 1 || phase == 2) ? ((phase == 1) ? 61 : 0) :
				((phase == 3) ? 36 : 0);
			stall_pct = (phase == 2) ? 61 : ((phase == 3) ? 36 : 0);
			for (chunk = 0; chunk < 5; chunk++) begin
				drain();
				pick = $urandom_range(9);
				case (pick)
					0: step_pick = 32'd65535;
					1: step_pick = 32'd0;
					2: step_pick = $urandom_range(65535);
					3: step_pick = 32'd1;
					default: step_pick = $urandom_range(1, 12);
				endcase
				apb_write(REG_STEP_TICKS, step_pick);
				apb_write(REG_COLOR_COUNT, $urandom_range(15));
				if (phase == 0 && chunk == 1) pressure_on = 1'b1;
				for (k = 0; k < 90; k++) begin
					c = ($urandom_range(9) < 7) ? CMD_TICK : CMD_LOAD;
					push_item(c, INDEX_W'($urandom_range(DEPTH - 1)), rgb_t'(24'($urandom)),
						1'b0, '0);
				end
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("** cyclic_color_gradient: PASSED **");
		end else begin
			$display("** cyclic_color_gradient: FAILED **");
		end
		$finish;
	end

endmodule
